>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL. Both expect clk and rst_n
// in scope and are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Condition that must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/irc_pkg.sv
// ----------------------------------------------------------------------------
// irc_pkg
// Shared types and constants for the entry reference-count cache.
// ----------------------------------------------------------------------------
`default_nettype none

package irc_pkg;

    // Slot table geometry: rows of LANES slots, one row compared per cycle
    localparam int SLOTS  = 128;
    localparam int SLOT_W = 7;
    localparam int LANES  = 8;
    localparam int LANE_W = 3;
    localparam int ROWS   = SLOTS / LANES;
    localparam int ROW_W  = 4;

    localparam int DRIVE_W  = 2;
    localparam int KEY_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int FREE_W   = 8;
    localparam int CFG_W    = 10;
    localparam int ZONE_W   = 16;
    localparam int OFFS_W   = 10;
    localparam int STATUS_W = 3;

    // APB register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_INODE_MAP = 1'b0;
    localparam logic REG_ZONE_MAP  = 1'b1;

    // On-disk layout
    localparam int ZONE_BYTES   = 1024;
    localparam int RECORD_BYTES = 32;
    localparam int PER_ZONE     = (ZONE_BYTES / RECORD_BYTES == 0) ? 1
                                : ZONE_BYTES / RECORD_BYTES;
    localparam int ZONE_BASE    = 2;

    // Request kinds
    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_ALLOC = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_OPEN  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FREED = 3'd4;
    localparam logic [STATUS_W-1:0] STS_BAD   = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] inode_map_blocks;
        logic [CFG_W-1:0] zone_map_blocks;
    } cfg_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [KEY_W-1:0]   key;
    } tag_t;

endpackage

`default_nettype wire

>>> design/irc_cfg_regs.sv
// ----------------------------------------------------------------------------
// irc_cfg_regs
// APB register file holding the two bitmap block counts.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irc_pkg::PADDR_W-1:0] paddr,
    input  logic [irc_pkg::PDATA_W-1:0] pwdata,
    output logic [irc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output irc_pkg::cfg_t               cfg
);
    import irc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_INODE_MAP: cfg_next.inode_map_blocks = pwdata[CFG_W-1:0];
                REG_ZONE_MAP:  cfg_next.zone_map_blocks  = pwdata[CFG_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_INODE_MAP: prdata = PDATA_W'(cfg_reg.inode_map_blocks);
            REG_ZONE_MAP:  prdata = PDATA_W'(cfg_reg.zone_map_blocks);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inode_map_blocks <= CFG_W'(1);
            cfg_reg.zone_map_blocks  <= CFG_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> design/inode_refcount_cache_unit.sv
// ----------------------------------------------------------------------------
// inode_refcount_cache_unit
// Cache of 128 open file entries keyed by (drive, entry number), with an
// open count per slot and a FIFO of free slots.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------
//  cfg       psel/penable/pready     paddr, pwdata (write), prdata (read)
//  in        in_valid / in_ready     kind, drive, entry_number, slot
//  out       out_valid / out_ready   status, slot_index, open_count,
//                                    load_zone, load_offset
//
//  One transaction at a time. An open scans the tag rows, one row of 8 slots
//  read from the tag RAM and compared per cycle over 16 rows, and stops at
//  the first row that hits; a miss is known after the last row. Reset is
//  immediate, no clearing pass: valid bits sit in flops and the free FIFO
//  reads unwritten places as their own index.
//  A waiting result in the output register does not block the next request;
//  a finished result waits in the result stage until the output is free.
//
`default_nettype none

`include "assert_macros.svh"

module inode_refcount_cache_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irc_pkg::PADDR_W-1:0]  paddr,
    input  logic [irc_pkg::PDATA_W-1:0]  pwdata,
    output logic [irc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [irc_pkg::DRIVE_W-1:0]  drive,
    input  logic [irc_pkg::KEY_W-1:0]    entry_number,
    input  logic [irc_pkg::SLOT_W-1:0]   slot,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [irc_pkg::STATUS_W-1:0] status,
    output logic [irc_pkg::SLOT_W-1:0]   slot_index,
    output logic [irc_pkg::COUNT_W-1:0]  open_count,
    output logic [irc_pkg::ZONE_W-1:0]   load_zone,
    output logic [irc_pkg::OFFS_W-1:0]   load_offset
);
    import irc_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SCAN   = 9'b000000010,
        ST_HIT    = 9'b000000100,
        ST_HITW   = 9'b000001000,
        ST_MISS   = 9'b000010000,
        ST_ALLOC  = 9'b000100000,
        ST_CLOSE  = 9'b001000000,
        ST_CLOSEW = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg;

    irc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t                        state_reg, state_next;
    logic [ROWS-1:0][LANES-1:0]    valid_reg, valid_next;
    logic [SLOT_W-1:0]             free_head_reg, free_head_next;
    logic [SLOT_W-1:0]             free_tail_reg, free_tail_next;
    logic                          free_wrap_reg, free_wrap_next;
    logic [FREE_W-1:0]             free_total_reg, free_total_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    logic                          out_valid_reg, out_valid_next;

    // Working payload
    tag_t                          key_reg, key_next;
    logic [SLOT_W-1:0]             work_slot_reg, work_slot_next;
    logic [ROW_W:0]                scan_rd_reg, scan_rd_next;
    logic [ROW_W-1:0]              cmp_row_reg, cmp_row_next;

    // Result stage and output register
    logic [STATUS_W-1:0]           res_status_reg, res_status_next;
    logic [SLOT_W-1:0]             res_slot_reg, res_slot_next;
    logic [COUNT_W-1:0]            res_count_reg, res_count_next;
    logic [ZONE_W-1:0]             res_zone_reg, res_zone_next;
    logic [OFFS_W-1:0]             res_offs_reg, res_offs_next;
    logic [STATUS_W-1:0]           out_status_reg, out_status_next;
    logic [SLOT_W-1:0]             out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]            out_count_reg, out_count_next;
    logic [ZONE_W-1:0]             out_zone_reg, out_zone_next;
    logic [OFFS_W-1:0]             out_offs_reg, out_offs_next;

    // ------------------------------------------------------------------
    // Memories: tag rows, open counts, free slot FIFO
    // ------------------------------------------------------------------
    tag_t [LANES-1:0]  tag_mem [ROWS];
    logic [COUNT_W-1:0] cnt_mem [SLOTS];
    logic [SLOT_W-1:0]  fq_mem  [SLOTS];

    tag_t [LANES-1:0]   tag_q;
    logic [COUNT_W-1:0] cnt_q;
    logic [SLOT_W-1:0]  fq_q;

    logic               tag_we;
    logic [ROW_W-1:0]   tag_wr_row;
    logic [LANE_W-1:0]  tag_wr_lane;
    logic [ROW_W-1:0]   tag_rd_row;
    logic               cnt_we;
    logic [SLOT_W-1:0]  cnt_wr_addr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               fq_we;

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wr_row][tag_wr_lane] <= key_reg;
        end
        tag_q <= tag_mem[tag_rd_row];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wr_addr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[work_slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (fq_we)
        begin
            fq_mem[free_tail_reg] <= work_slot_reg;
        end
        fq_q <= fq_mem[free_head_reg];
    end

    // ------------------------------------------------------------------
    // Row compare: 8 lanes against the key, lowest matching lane wins
    // ------------------------------------------------------------------
    logic [LANES-1:0]  lane_match;
    logic              row_hit;
    logic [LANE_W-1:0] hit_lane;

    always_comb
    begin
        hit_lane = '0;
        for (int l = 0; l < LANES; l++)
        begin
            lane_match[l] = valid_reg[cmp_row_reg][l] && (tag_q[l] == key_reg);
        end
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (lane_match[l])
            begin
                hit_lane = LANE_W'(l);
            end
        end
    end

    assign row_hit = |lane_match;

    // ------------------------------------------------------------------
    // Allocation: popped slot and disk location of the record
    // ------------------------------------------------------------------
    logic               head_written;
    logic [SLOT_W-1:0]  alloc_slot;
    logic [KEY_W-1:0]   rec_idx;
    logic [ZONE_W:0]    zone_sum;
    logic [ZONE_W-1:0]  zone_sat;
    logic [OFFS_W-1:0]  rec_offs;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] cnt_dec;

    // FIFO places not yet written since reset still hold their own index
    assign head_written = free_wrap_reg || (free_head_reg < free_tail_reg);
    assign alloc_slot   = head_written ? fq_q : free_head_reg;

    assign rec_idx  = key_reg.key - KEY_W'(1);
    assign zone_sum = (ZONE_W+1)'(ZONE_BASE)
                    + (ZONE_W+1)'(cfg.inode_map_blocks)
                    + (ZONE_W+1)'(cfg.zone_map_blocks)
                    + (ZONE_W+1)'(rec_idx / PER_ZONE);
    assign zone_sat = zone_sum[ZONE_W] ? '1 : zone_sum[ZONE_W-1:0];
    assign rec_offs = OFFS_W'((rec_idx % PER_ZONE) * RECORD_BYTES);

    assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);
    assign cnt_dec = (cnt_q == '0) ? cnt_q : cnt_q - COUNT_W'(1);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_ready   = (state_reg == ST_IDLE);
    assign tag_rd_row = scan_rd_reg[ROW_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        free_wrap_next  = free_wrap_reg;
        free_total_next = free_total_reg;
        cmp_vld_next    = cmp_vld_reg;
        out_valid_next  = out_valid_reg;
        key_next        = key_reg;
        work_slot_next  = work_slot_reg;
        scan_rd_next    = scan_rd_reg;
        cmp_row_next    = cmp_row_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        res_zone_next   = res_zone_reg;
        res_offs_next   = res_offs_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        out_zone_next   = out_zone_reg;
        out_offs_next   = out_offs_reg;
        tag_we          = 1'b0;
        tag_wr_row      = alloc_slot[SLOT_W-1:LANE_W];
        tag_wr_lane     = alloc_slot[LANE_W-1:0];
        cnt_we          = 1'b0;
        cnt_wr_addr     = work_slot_reg;
        cnt_wdata       = cnt_dec;
        fq_we           = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next.drive = drive;
                    key_next.key   = entry_number;
                    work_slot_next = slot;
                    if (kind == KIND_OPEN)
                    begin
                        scan_rd_next = '0;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_CLOSE;
                    end
                end
            end

            ST_SCAN:
            begin
                // read row n while comparing row n-1
                if (!scan_rd_reg[ROW_W])
                begin
                    scan_rd_next = scan_rd_reg + (ROW_W+1)'(1);
                    cmp_vld_next = 1'b1;
                    cmp_row_next = scan_rd_reg[ROW_W-1:0];
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
                if (cmp_vld_reg)
                begin
                    if (row_hit)
                    begin
                        work_slot_next = {cmp_row_reg, hit_lane};
                        state_next     = ST_HIT;
                    end
                    else if (cmp_row_reg == ROW_LAST)
                    begin
                        state_next = ST_MISS;
                    end
                end
            end

            ST_HIT:
            begin
                state_next = ST_HITW;
            end

            ST_HITW:
            begin
                cnt_we          = 1'b1;
                cnt_wdata       = cnt_inc;
                res_status_next = STS_HIT;
                res_slot_next   = work_slot_reg;
                res_count_next  = cnt_inc;
                res_zone_next   = '0;
                res_offs_next   = '0;
                state_next      = ST_OUT;
            end

            ST_MISS:
            begin
                if (free_total_reg == '0)
                begin
                    res_status_next = STS_FULL;
                    res_slot_next   = '0;
                    res_count_next  = '0;
                    res_zone_next   = '0;
                    res_offs_next   = '0;
                    state_next      = ST_OUT;
                end
                else
                begin
                    state_next = ST_ALLOC;
                end
            end

            ST_ALLOC:
            begin
                free_head_next  = (free_head_reg == SLOT_LAST) ? '0
                                : free_head_reg + SLOT_W'(1);
                free_total_next = free_total_reg - FREE_W'(1);
                valid_next[alloc_slot[SLOT_W-1:LANE_W]][alloc_slot[LANE_W-1:0]] = 1'b1;
                tag_we          = 1'b1;
                cnt_we          = 1'b1;
                cnt_wr_addr     = alloc_slot;
                cnt_wdata       = COUNT_W'(1);
                res_status_next = STS_ALLOC;
                res_slot_next   = alloc_slot;
                res_count_next  = COUNT_W'(1);
                res_zone_next   = zone_sat;
                res_offs_next   = rec_offs;
                state_next      = ST_OUT;
            end

            ST_CLOSE:
            begin
                if (!valid_reg[work_slot_reg[SLOT_W-1:LANE_W]][work_slot_reg[LANE_W-1:0]])
                begin
                    res_status_next = STS_BAD;
                    res_slot_next   = work_slot_reg;
                    res_count_next  = '0;
                    res_zone_next   = '0;
                    res_offs_next   = '0;
                    state_next      = ST_OUT;
                end
                else
                begin
                    state_next = ST_CLOSEW;
                end
            end

            ST_CLOSEW:
            begin
                cnt_we         = 1'b1;
                res_slot_next  = work_slot_reg;
                res_count_next = cnt_dec;
                res_zone_next  = '0;
                res_offs_next  = '0;
                if (cnt_dec != '0)
                begin
                    res_status_next = STS_OPEN;
                end
                else
                begin
                    res_status_next = STS_FREED;
                    valid_next[work_slot_reg[SLOT_W-1:LANE_W]][work_slot_reg[LANE_W-1:0]]
                        = 1'b0;
                    if (free_total_reg < FREE_W'(SLOTS))
                    begin
                        fq_we           = 1'b1;
                        free_tail_next  = (free_tail_reg == SLOT_LAST) ? '0
                                        : free_tail_reg + SLOT_W'(1);
                        free_total_next = free_total_reg + FREE_W'(1);
                        if (free_tail_reg == SLOT_LAST)
                        begin
                            free_wrap_next = 1'b1;
                        end
                    end
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_count_next  = res_count_reg;
                    out_zone_next   = res_zone_reg;
                    out_offs_next   = res_offs_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            free_head_reg  <= '0;
            free_tail_reg  <= '0;
            free_wrap_reg  <= 1'b0;
            free_total_reg <= FREE_W'(SLOTS);
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            free_wrap_reg  <= free_wrap_next;
            free_total_reg <= free_total_next;
            cmp_vld_reg    <= cmp_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        work_slot_reg  <= work_slot_next;
        scan_rd_reg    <= scan_rd_next;
        cmp_row_reg    <= cmp_row_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_count_reg  <= res_count_next;
        res_zone_reg   <= res_zone_next;
        res_offs_reg   <= res_offs_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
        out_zone_reg   <= out_zone_next;
        out_offs_reg   <= out_offs_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_index  = out_slot_reg;
    assign open_count  = out_count_reg;
    assign load_zone   = out_zone_reg;
    assign load_offset = out_offs_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // every slot is either in use or waiting in the free FIFO
    `ASSERT_ALWAYS(a_slot_conserve, (9'($countones(valid_reg)) + 9'(free_total_reg)) == 9'(SLOTS), "slot count and free total disagree")
    // FIFO pointers span exactly the free total
    `ASSERT_ALWAYS(a_queue_span, SLOT_W'(free_tail_reg - free_head_reg) == free_total_reg[SLOT_W-1:0], "free FIFO pointers out of step")
    `ASSERT_ALWAYS(a_free_bound, free_total_reg <= FREE_W'(SLOTS), "free total above slot count")
    `ASSERT_IMPLIES(a_alloc_free, state_reg == ST_ALLOC, free_total_reg != '0, "allocation with empty free FIFO")

endmodule

`default_nettype wire
